[rtl/svf_pkg.sv]
// Shared constants, register codes and types for the state variable filter.
package svf_pkg;

	// Default widths of the sample path and the integrator state
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int STATE_WIDTH_DEF  = 32;

	// Coefficient format: unsigned Q.22
	localparam int FRAC_BITS   = 22;
	localparam int COEF_WIDTH  = 24;
	localparam int FREQ_WIDTH  = 23;
	localparam int DAMP_WIDTH  = 24;
	localparam int LEVEL_WIDTH = 23;

	// Upper limits applied when a register is written
	localparam int FREQ_MAX  = 5931642;
	localparam int DAMP_MAX  = 8388608;
	localparam int LEVEL_MAX = 4194304;

	// Register map
	localparam int REG_IDX_WIDTH = 3;
	localparam logic [REG_IDX_WIDTH-1:0] REG_FREQ  = REG_IDX_WIDTH'(0);
	localparam logic [REG_IDX_WIDTH-1:0] REG_DAMP  = REG_IDX_WIDTH'(1);
	localparam logic [REG_IDX_WIDTH-1:0] REG_LOW   = REG_IDX_WIDTH'(2);
	localparam logic [REG_IDX_WIDTH-1:0] REG_BAND  = REG_IDX_WIDTH'(3);
	localparam logic [REG_IDX_WIDTH-1:0] REG_HIGH  = REG_IDX_WIDTH'(4);
	localparam logic [REG_IDX_WIDTH-1:0] REG_NOTCH = REG_IDX_WIDTH'(5);
	localparam logic [REG_IDX_WIDTH-1:0] REG_PEAK  = REG_IDX_WIDTH'(6);

	// Clipped register contents as seen by the datapath
	typedef struct packed {
		logic [FREQ_WIDTH-1:0]  freq;
		logic [DAMP_WIDTH-1:0]  damp;
		logic [LEVEL_WIDTH-1:0] low_lvl;
		logic [LEVEL_WIDTH-1:0] band_lvl;
		logic [LEVEL_WIDTH-1:0] high_lvl;
		logic [LEVEL_WIDTH-1:0] notch_lvl;
		logic [LEVEL_WIDTH-1:0] peak_lvl;
	} cfg_t;

endpackage

[rtl/svf_mul.sv]
// Shared multi-cycle multiplier: floor(a * c / 2^22) from two partial products.
module svf_mul #(
	parameter int OP_WIDTH = svf_pkg::STATE_WIDTH_DEF + 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [OP_WIDTH-1:0]           a,
	input  logic        [svf_pkg::COEF_WIDTH-1:0] c,
	output logic                                 done,
	output logic signed [OP_WIDTH+1:0]           res
);

	localparam int LO_W   = (OP_WIDTH + 1) / 2;
	localparam int HI_W   = OP_WIDTH - LO_W;
	localparam int MA_W   = LO_W + 1;
	localparam int PP_W   = MA_W + svf_pkg::COEF_WIDTH + 1;
	localparam int FULL_W = OP_WIDTH + svf_pkg::COEF_WIDTH + 1;
	localparam int RES_W  = OP_WIDTH + 2;

	localparam logic [1:0] PH_LO  = 2'd0;
	localparam logic [1:0] PH_HI  = 2'd1;
	localparam logic [1:0] PH_SUM = 2'd2;

	logic                               busy_q;
	logic [1:0]                         ph_q;
	logic                               done_q;
	logic signed [OP_WIDTH-1:0]         a_q;
	logic        [svf_pkg::COEF_WIDTH-1:0] c_q;
	logic signed [PP_W-1:0]             pp_lo_q;
	logic signed [PP_W-1:0]             pp_hi_q;
	logic signed [RES_W-1:0]            res_q;

	logic signed [MA_W-1:0]                  op_sel;
	logic signed [svf_pkg::COEF_WIDTH:0]     c_sg;
	logic signed [PP_W-1:0]                  pp;
	logic signed [FULL_W-1:0]                hi_ext;
	logic signed [FULL_W-1:0]                lo_ext;
	logic signed [FULL_W-1:0]                full;

	// Low half zero-extended, high half sign-extended, through one multiplier
	always_comb begin
		if (ph_q == PH_LO) begin
			op_sel = $signed({1'b0, a_q[LO_W-1:0]});
		end else begin
			op_sel = $signed({{(MA_W-HI_W){a_q[OP_WIDTH-1]}}, a_q[OP_WIDTH-1:LO_W]});
		end
	end

	assign c_sg = $signed({1'b0, c_q});
	assign pp   = op_sel * c_sg;

	// Recombine the partial products and drop the fraction (floor)
	assign hi_ext = FULL_W'(pp_hi_q);
	assign lo_ext = FULL_W'(pp_lo_q);
	assign full   = (hi_ext <<< LO_W) + lo_ext;

	// Phase control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= PH_LO;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					ph_q   <= PH_LO;
				end
			end else begin
				case (ph_q)
					PH_LO:   ph_q <= PH_HI;
					PH_HI:   ph_q <= PH_SUM;
					PH_SUM: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						ph_q   <= PH_LO;
					end
					default: ph_q <= PH_LO;
				endcase
			end
		end
	end

	// Operand latch and partial product registers
	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			a_q <= a;
			c_q <= c;
		end
		if (busy_q && ph_q == PH_LO) pp_lo_q <= pp;
		if (busy_q && ph_q == PH_HI) pp_hi_q <= pp;
		if (busy_q && ph_q == PH_SUM) res_q <= $signed(full[svf_pkg::FRAC_BITS +: RES_W]);
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/svf_cfg.sv]
// Configuration register file with range clipping on write.
module svf_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [svf_pkg::REG_IDX_WIDTH-1:0]      index,
	input  logic [svf_pkg::COEF_WIDTH-1:0]         data,
	output svf_pkg::cfg_t                          cfg
);

	svf_pkg::cfg_t                        cfg_q;
	logic [svf_pkg::FREQ_WIDTH-1:0]       freq_w;
	logic [svf_pkg::FREQ_WIDTH-1:0]       freq_clip;
	logic [svf_pkg::DAMP_WIDTH-1:0]       damp_w;
	logic [svf_pkg::DAMP_WIDTH-1:0]       damp_clip;
	logic [svf_pkg::LEVEL_WIDTH-1:0]      lvl_w;
	logic [svf_pkg::LEVEL_WIDTH-1:0]      lvl_clip;

	// Drop the upper bits, then clamp to the legal maximum
	always_comb begin
		freq_w = data[svf_pkg::FREQ_WIDTH-1:0];
		damp_w = data[svf_pkg::DAMP_WIDTH-1:0];
		lvl_w  = data[svf_pkg::LEVEL_WIDTH-1:0];
		freq_clip = (freq_w > svf_pkg::FREQ_WIDTH'(svf_pkg::FREQ_MAX)) ?
			svf_pkg::FREQ_WIDTH'(svf_pkg::FREQ_MAX) : freq_w;
		damp_clip = (damp_w > svf_pkg::DAMP_WIDTH'(svf_pkg::DAMP_MAX)) ?
			svf_pkg::DAMP_WIDTH'(svf_pkg::DAMP_MAX) : damp_w;
		lvl_clip  = (lvl_w > svf_pkg::LEVEL_WIDTH'(svf_pkg::LEVEL_MAX)) ?
			svf_pkg::LEVEL_WIDTH'(svf_pkg::LEVEL_MAX) : lvl_w;
	end

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freq      <= '0;
			cfg_q.damp      <= '0;
			cfg_q.low_lvl   <= svf_pkg::LEVEL_WIDTH'(svf_pkg::LEVEL_MAX);
			cfg_q.band_lvl  <= '0;
			cfg_q.high_lvl  <= '0;
			cfg_q.notch_lvl <= '0;
			cfg_q.peak_lvl  <= '0;
		end else if (wr_en) begin
			case (index)
				svf_pkg::REG_FREQ:  cfg_q.freq      <= freq_clip;
				svf_pkg::REG_DAMP:  cfg_q.damp      <= damp_clip;
				svf_pkg::REG_LOW:   cfg_q.low_lvl   <= lvl_clip;
				svf_pkg::REG_BAND:  cfg_q.band_lvl  <= lvl_clip;
				svf_pkg::REG_HIGH:  cfg_q.high_lvl  <= lvl_clip;
				svf_pkg::REG_NOTCH: cfg_q.notch_lvl <= lvl_clip;
				svf_pkg::REG_PEAK:  cfg_q.peak_lvl  <= lvl_clip;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/state_variable_filter.sv]
// Words are taken one at a time; in_ready returns with the result.
// Each sample uses the shared multiplier 11 times, plus two high-pass steps, the output
// step and the idle state in which the next word is taken.
// A result not yet taken holds the final step until out_ready; a new word may then enter.
// Reset (arst_n low) clears both integrators, loads register defaults (low level 1.0,
// all else 0) and drops any pending result.
module state_variable_filter #(
	parameter int SAMPLE_WIDTH = svf_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH  = svf_pkg::STATE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]        in_sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]        out_sample,
	input  logic                                  cfg_wr_en,
	input  logic [svf_pkg::REG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [svf_pkg::COEF_WIDTH-1:0]        cfg_data
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int W    = STATE_WIDTH;
	localparam int SUMW = W + 2;
	localparam int MRW  = SUMW + 2;
	localparam int XW   = ((SW > W) ? SW : W) + 6;

	localparam logic signed [XW-1:0] ST_MAX  = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] ST_MIN  = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [XW-1:0] SMP_MAX = {{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [XW-1:0] SMP_MIN = {{(XW-SW+1){1'b1}}, {(SW-1){1'b0}}};

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_NOTCH = 3'd1;
	localparam logic [2:0] S_LOW   = 3'd2;
	localparam logic [2:0] S_HIGH  = 3'd3;
	localparam logic [2:0] S_BAND  = 3'd4;
	localparam logic [2:0] S_MIX   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	// Mix term order
	localparam logic [2:0] MIX_LOW   = 3'd0;
	localparam logic [2:0] MIX_BAND  = 3'd1;
	localparam logic [2:0] MIX_HIGH  = 3'd2;
	localparam logic [2:0] MIX_NOTCH = 3'd3;
	localparam logic [2:0] MIX_PEAK  = 3'd4;

	function automatic logic signed [W-1:0] sat_st(input logic signed [XW-1:0] v);
		if (v > ST_MAX) return ST_MAX[W-1:0];
		if (v < ST_MIN) return ST_MIN[W-1:0];
		return v[W-1:0];
	endfunction

	function automatic logic signed [SW-1:0] sat_smp(input logic signed [XW-1:0] v);
		if (v > SMP_MAX) return SMP_MAX[SW-1:0];
		if (v < SMP_MIN) return SMP_MIN[SW-1:0];
		return v[SW-1:0];
	endfunction

	svf_pkg::cfg_t cfg;

	logic [2:0]               state_q;
	logic                     pend_q;
	logic                     pass_q;
	logic [2:0]               mix_q;
	logic signed [SW-1:0]     x_q;
	logic signed [W-1:0]      low_q;
	logic signed [W-1:0]      band_q;
	logic signed [W-1:0]      notch_q;
	logic signed [W-1:0]      high_q;
	logic signed [SUMW-1:0]   s_low_q;
	logic signed [SUMW-1:0]   s_band_q;
	logic signed [SUMW-1:0]   s_high_q;
	logic signed [SUMW-1:0]   s_notch_q;
	logic signed [SUMW-1:0]   s_peak_q;
	logic signed [XW-1:0]     acc_q;
	logic                     out_valid_q;
	logic signed [SW-1:0]     out_sample_q;

	logic                               mul_state;
	logic                               mul_start;
	logic                               mul_done;
	logic signed [SUMW-1:0]             mul_a;
	logic [svf_pkg::COEF_WIDTH-1:0]     mul_c;
	logic signed [MRW-1:0]              mul_res;
	logic signed [XW-1:0]               mres_x;
	logic signed [W-1:0]                notch_new;
	logic signed [W-1:0]                low_new;
	logic signed [W-1:0]                high_new;
	logic signed [W-1:0]                band_new;
	logic signed [SUMW-1:0]             peak_term;
	logic signed [SW-1:0]               out_new;

	svf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	svf_mul #(
		.OP_WIDTH (SUMW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.c      (mul_c),
		.done   (mul_done),
		.res    (mul_res)
	);

	// Multiplier operand select per step
	always_comb begin
		mul_a = '0;
		mul_c = '0;
		case (state_q)
			S_NOTCH: begin
				mul_a = SUMW'(band_q);
				mul_c = cfg.damp;
			end
			S_LOW: begin
				mul_a = SUMW'(band_q);
				mul_c = svf_pkg::COEF_WIDTH'(cfg.freq);
			end
			S_BAND: begin
				mul_a = SUMW'(high_q);
				mul_c = svf_pkg::COEF_WIDTH'(cfg.freq);
			end
			S_MIX: begin
				case (mix_q)
					MIX_LOW: begin
						mul_a = s_low_q;
						mul_c = svf_pkg::COEF_WIDTH'(cfg.low_lvl);
					end
					MIX_BAND: begin
						mul_a = s_band_q;
						mul_c = svf_pkg::COEF_WIDTH'(cfg.band_lvl);
					end
					MIX_HIGH: begin
						mul_a = s_high_q;
						mul_c = svf_pkg::COEF_WIDTH'(cfg.high_lvl);
					end
					MIX_NOTCH: begin
						mul_a = s_notch_q;
						mul_c = svf_pkg::COEF_WIDTH'(cfg.notch_lvl);
					end
					MIX_PEAK: begin
						mul_a = s_peak_q;
						mul_c = svf_pkg::COEF_WIDTH'(cfg.peak_lvl);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign mul_state = (state_q == S_NOTCH) || (state_q == S_LOW) ||
		(state_q == S_BAND) || (state_q == S_MIX);
	assign mul_start = mul_state && !pend_q;

	// Saturating updates of the filter variables
	assign mres_x    = XW'(mul_res);
	assign notch_new = sat_st(XW'(x_q) - mres_x);
	assign low_new   = sat_st(XW'(low_q) + mres_x);
	assign high_new  = sat_st(XW'(notch_q) - XW'(low_q));
	assign band_new  = sat_st(mres_x + XW'(band_q));
	assign peak_term = SUMW'(low_q) - SUMW'(high_new);
	assign out_new   = sat_smp(acc_q >>> 1);

	// Sequencer: two filter passes, then the five-term mix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pend_q       <= 1'b0;
			pass_q       <= 1'b0;
			mix_q        <= MIX_LOW;
			x_q          <= '0;
			low_q        <= '0;
			band_q       <= '0;
			notch_q      <= '0;
			high_q       <= '0;
			s_low_q      <= '0;
			s_band_q     <= '0;
			s_high_q     <= '0;
			s_notch_q    <= '0;
			s_peak_q     <= '0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
		end else begin
			// S_OUT reloads the output word itself
			if (out_valid_q && out_ready && (state_q != S_OUT)) out_valid_q <= 1'b0;
			if (mul_start) pend_q <= 1'b1;
			if (mul_done) pend_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q       <= in_sample;
						pass_q    <= 1'b0;
						s_low_q   <= '0;
						s_band_q  <= '0;
						s_high_q  <= '0;
						s_notch_q <= '0;
						s_peak_q  <= '0;
						acc_q     <= '0;
						state_q   <= S_NOTCH;
					end
				end
				S_NOTCH: begin
					if (mul_done) begin
						notch_q <= notch_new;
						state_q <= S_LOW;
					end
				end
				S_LOW: begin
					if (mul_done) begin
						low_q   <= low_new;
						state_q <= S_HIGH;
					end
				end
				S_HIGH: begin
					high_q    <= high_new;
					s_low_q   <= s_low_q + SUMW'(low_q);
					s_notch_q <= s_notch_q + SUMW'(notch_q);
					s_high_q  <= s_high_q + SUMW'(high_new);
					s_peak_q  <= s_peak_q + peak_term;
					state_q   <= S_BAND;
				end
				S_BAND: begin
					if (mul_done) begin
						band_q   <= band_new;
						s_band_q <= s_band_q + SUMW'(band_new);
						if (pass_q) begin
							mix_q   <= MIX_LOW;
							state_q <= S_MIX;
						end else begin
							pass_q  <= 1'b1;
							state_q <= S_NOTCH;
						end
					end
				end
				S_MIX: begin
					if (mul_done) begin
						acc_q <= acc_q + mres_x;
						if (mix_q == MIX_PEAK) begin
							state_q <= S_OUT;
						end else begin
							mix_q <= mix_q + 3'd1;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_sample_q <= out_new;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

endmodule

[rtl/svf_check.sv]
// Port-level checks for the state variable filter, bound to the top level.
module svf_check #(
	parameter int SAMPLE_WIDTH = svf_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] out_sample
);

	// One word in flight: ready drops right after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after a word was accepted");

	// A result cannot appear in the cycle after acceptance
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("out_valid rose right after acceptance");

	// The block becomes ready again exactly when it posts its result
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> out_valid)
		else $error("in_ready returned without a posted result");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
		else $error("stalled output word changed or dropped");

endmodule

bind state_variable_filter svf_check #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_svf_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_sample (out_sample)
);
